>>> rtl/sud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sud_pkg
// Shared types and constants for the pipelined signed/unsigned divider.
// ----------------------------------------------------------------------------
package sud_pkg;

  localparam int unsigned DIV_WIDTH = 32;

  typedef enum logic [1:0] {
    FUNC_UQUO = 2'd0,
    FUNC_UREM = 2'd1,
    FUNC_SQUO = 2'd2,
    FUNC_SREM = 2'd3
  } func_e;

  // control that travels with an item down the pipeline
  typedef struct packed {
    logic valid;
    logic rem_sel;
    logic neg_res;
    logic zero;
  } ctrl_t;

endpackage

>>> rtl/sud_pre.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sud_pre
// Input stage: decodes the operation, takes operand magnitudes and registers
// the item for the first step cell.
// ----------------------------------------------------------------------------
module sud_pre #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           func_i,
  input  logic [WIDTH-1:0]     dividend_i,
  input  logic [WIDTH-1:0]     divisor_i,
  output sud_pkg::ctrl_t       ctrl_o,
  output logic [WIDTH-1:0]     nq_o,
  output logic [WIDTH-1:0]     dvs_o
);
  import sud_pkg::*;

  logic           is_signed;
  logic           want_rem;
  logic           a_neg;
  logic           b_neg;
  logic [WIDTH-1:0] a_mag;
  logic [WIDTH-1:0] b_mag;
  ctrl_t          ctrl_d, ctrl_q;
  logic [WIDTH-1:0] nq_q;
  logic [WIDTH-1:0] dvs_q;

  always_comb begin
    unique case (func_e'(func_i))
      FUNC_UQUO: begin
        is_signed = 1'b0;
        want_rem  = 1'b0;
      end
      FUNC_UREM: begin
        is_signed = 1'b0;
        want_rem  = 1'b1;
      end
      FUNC_SQUO: begin
        is_signed = 1'b1;
        want_rem  = 1'b0;
      end
      default: begin
        is_signed = 1'b1;
        want_rem  = 1'b1;
      end
    endcase
    a_neg = is_signed & dividend_i[WIDTH-1];
    b_neg = is_signed & divisor_i[WIDTH-1];
    a_mag = a_neg ? (~dividend_i + {{(WIDTH-1){1'b0}}, 1'b1}) : dividend_i;
    b_mag = b_neg ? (~divisor_i + {{(WIDTH-1){1'b0}}, 1'b1}) : divisor_i;
    ctrl_d.valid   = accept_i;
    ctrl_d.rem_sel = want_rem;
    ctrl_d.neg_res = want_rem ? a_neg : (a_neg ^ b_neg);
    ctrl_d.zero    = (divisor_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= a_mag;
    dvs_q <= b_mag;
  end

  assign ctrl_o = ctrl_q;
  assign nq_o   = nq_q;
  assign dvs_o  = dvs_q;

endmodule

>>> rtl/sud_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sud_cell
// One restoring division step: shifts the next dividend bit into the partial
// remainder, subtracts the divisor when it fits and shifts in a quotient bit.
// ----------------------------------------------------------------------------
module sud_cell #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sud_pkg::ctrl_t       ctrl_i,
  input  logic [WIDTH-1:0]     rem_i,
  input  logic [WIDTH-1:0]     nq_i,
  input  logic [WIDTH-1:0]     dvs_i,
  output sud_pkg::ctrl_t       ctrl_o,
  output logic [WIDTH-1:0]     rem_o,
  output logic [WIDTH-1:0]     nq_o,
  output logic [WIDTH-1:0]     dvs_o
);
  import sud_pkg::*;

  logic [WIDTH-1:0] shifted;
  logic             fits;
  ctrl_t            ctrl_q;
  logic [WIDTH-1:0] rem_d, rem_q;
  logic [WIDTH-1:0] nq_d, nq_q;
  logic [WIDTH-1:0] dvs_q;

  always_comb begin
    shifted = {rem_i[WIDTH-2:0], nq_i[WIDTH-1]};
    fits    = (shifted >= dvs_i);
    rem_d   = fits ? (shifted - dvs_i) : shifted;
    nq_d    = {nq_i[WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    dvs_q <= dvs_i;
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign nq_o   = nq_q;
  assign dvs_o  = dvs_q;

endmodule

>>> rtl/sud_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sud_post
// Output stage: selects quotient or remainder, applies the sign and forces
// zero for a zero divisor, then registers the result and its strobe.
// ----------------------------------------------------------------------------
module sud_post #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sud_pkg::ctrl_t       ctrl_i,
  input  logic [WIDTH-1:0]     rem_i,
  input  logic [WIDTH-1:0]     quo_i,
  output logic                 valid_o,
  output logic [WIDTH-1:0]     result_o
);
  import sud_pkg::*;

  logic [WIDTH-1:0] sel;
  logic [WIDTH-1:0] result_d, result_q;
  logic             valid_q;

  always_comb begin
    sel = ctrl_i.rem_sel ? rem_i : quo_i;
    if (ctrl_i.zero) begin
      result_d = '0;
    end else if (ctrl_i.neg_res) begin
      result_d = ~sel + {{(WIDTH-1){1'b0}}, 1'b1};
    end else begin
      result_d = sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

>>> rtl/signed_unsigned_divider_32_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_unsigned_divider_32_unit
// Pipelined restoring integer divider: unsigned and signed quotient and
// remainder, one item per clock.
// ----------------------------------------------------------------------------
// usage:
//   an item (func_i, dividend_i, divisor_i) is taken at a rising edge with
//   start high and busy low. busy is tied low: the pipeline never stalls.
//   func_i: 0 unsigned quotient, 1 unsigned remainder, 2 signed quotient,
//   3 signed remainder. a zero divisor gives a result of zero.
//   the result shows on result_o for one cycle with valid_o high, once the
//   item has passed the magnitude register, which loads at the accepting
//   edge, a row of WIDTH step cells and the sign fixup with the output
//   register; the receiver takes it at the edge that samples valid_o high.
//   throughput is one item per cycle, set by each step cell doing one
//   quotient bit and passing its item on at every edge.
//   results arrive in the order items were taken; there is no hold-off from
//   the receiver. reset clears every valid flag in the pipeline, dropping
//   items in flight; operand data is not reset.
// ----------------------------------------------------------------------------
module signed_unsigned_divider_32_unit #(
  parameter int unsigned WIDTH = sud_pkg::DIV_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       func_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] result_o
);
  import sud_pkg::*;

  localparam int unsigned LAT = WIDTH + 2;

  ctrl_t            ctrl_c [WIDTH+1];
  logic [WIDTH-1:0] rem_c  [WIDTH+1];
  logic [WIDTH-1:0] nq_c   [WIDTH+1];
  logic [WIDTH-1:0] dvs_c  [WIDTH+1];

  assign busy     = 1'b0;
  assign rem_c[0] = '0;

  sud_pre #(.WIDTH(WIDTH)) u_pre (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (start & ~busy),
    .func_i     (func_i),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .ctrl_o     (ctrl_c[0]),
    .nq_o       (nq_c[0]),
    .dvs_o      (dvs_c[0])
  );

  for (genvar g = 0; g < WIDTH; g++) begin : g_cell
    sud_cell #(.WIDTH(WIDTH)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_c[g]),
      .rem_i  (rem_c[g]),
      .nq_i   (nq_c[g]),
      .dvs_i  (dvs_c[g]),
      .ctrl_o (ctrl_c[g+1]),
      .rem_o  (rem_c[g+1]),
      .nq_o   (nq_c[g+1]),
      .dvs_o  (dvs_c[g+1])
    );
  end

  sud_post #(.WIDTH(WIDTH)) u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl_c[WIDTH]),
    .rem_i    (rem_c[WIDTH]),
    .quo_i    (nq_c[WIDTH]),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  a_strobe_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, LAT))
    else $error("result strobe without an item taken");

  a_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ($past(divisor_i, LAT) == '0) |-> (result_o == '0))
    else $error("zero divisor gave nonzero result");

  a_unit_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ($past(func_i, LAT) == FUNC_UQUO)
      && ($past(divisor_i, LAT) == {{(WIDTH-1){1'b0}}, 1'b1})
      |-> (result_o == $past(dividend_i, LAT)))
    else $error("unsigned divide by one mismatch");

endmodule
